// ----- rtl/lidar_cluster_to_image_columns_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the cluster window block.
// ----------------------------------------------------------------------------
`ifndef LIDAR_CLUSTER_TO_IMAGE_COLUMNS_UNIT_DEFINES_SVH
`define LIDAR_CLUSTER_TO_IMAGE_COLUMNS_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define LCIC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define LCIC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/lcic_pkg.sv -----
// ----------------------------------------------------------------------------
// lcic_pkg
// Types, constants and the arctangent table of the cluster window block.
// ----------------------------------------------------------------------------
package lcic_pkg;

  localparam int COORD_WIDTH_DEF  = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int MAX_STEPS        = 24;
  // coordinates enter the rotator scaled to this many bits of magnitude
  localparam int SCALE_REF        = 40;
  localparam int LANE_W           = 43;
  localparam int Z_W              = 28;
  localparam int ANG_W            = 16;

  localparam logic signed [ANG_W-1:0] ANG_PI      = 16'sd25736;
  localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 16'sd12868;
  localparam logic [12:0]             WIN_MAX     = 13'd4096;

  localparam logic [2:0] ST_IN_RANGE   = 3'd0;
  localparam logic [2:0] ST_LEFT_CLIP  = 3'd1;
  localparam logic [2:0] ST_RIGHT_CLIP = 3'd2;
  localparam logic [2:0] ST_BOTH_CLIP  = 3'd3;
  localparam logic [2:0] ST_OUTSIDE    = 3'd4;
  localparam logic [2:0] ST_ORDER_ERR  = 3'd5;
  localparam logic [2:0] ST_BOUNDARY   = 3'd6;

  localparam logic [1:0] REG_HALF_FOV  = 2'd0;
  localparam logic [1:0] REG_PIX_RATE  = 2'd1;
  localparam logic [1:0] REG_IMG_WIDTH = 2'd2;

  localparam logic [13:0] HALF_FOV_RST  = 14'd4289;
  localparam logic [12:0] PIX_RATE_RST  = 13'd611;
  localparam logic [12:0] IMG_WIDTH_RST = 13'd640;

  typedef struct packed {
    logic signed [LANE_W-1:0] x;
    logic signed [LANE_W-1:0] y;
    logic signed [Z_W-1:0]    z;
    logic                     fixed;
    logic signed [ANG_W-1:0]  fixed_ang;
    logic signed [ANG_W-1:0]  base;
  } lane_t;

  typedef struct packed {
    logic [13:0] half_fov;
    logic [12:0] pix_rate;
    logic [12:0] img_width;
  } cfg_t;

  typedef struct packed {
    logic [2:0]              status;
    logic signed [ANG_W-1:0] left_angle;
    logic signed [ANG_W-1:0] right_angle;
    logic [12:0]             offset;
    logic [12:0]             width;
  } result_t;

  // atan(2^-i) in Q24
  function automatic logic [Z_W-1:0] atan_entry(input logic [4:0] idx);
    logic [Z_W-1:0] v;
    case (idx)
      5'd0:  v = 28'd13176795;
      5'd1:  v = 28'd7778716;
      5'd2:  v = 28'd4110060;
      5'd3:  v = 28'd2086331;
      5'd4:  v = 28'd1047214;
      5'd5:  v = 28'd524117;
      5'd6:  v = 28'd262123;
      5'd7:  v = 28'd131069;
      5'd8:  v = 28'd65536;
      5'd9:  v = 28'd32768;
      5'd10: v = 28'd16384;
      5'd11: v = 28'd8192;
      5'd12: v = 28'd4096;
      5'd13: v = 28'd2048;
      5'd14: v = 28'd1024;
      5'd15: v = 28'd512;
      5'd16: v = 28'd256;
      5'd17: v = 28'd128;
      5'd18: v = 28'd64;
      5'd19: v = 28'd32;
      5'd20: v = 28'd16;
      5'd21: v = 28'd8;
      5'd22: v = 28'd4;
      5'd23: v = 28'd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/lcic_tracker.sv -----
// ----------------------------------------------------------------------------
// lcic_tracker
// Keeps the least-y and greatest-y points of the open cluster and loads
// both kept points into the rotator on the last point.
// ----------------------------------------------------------------------------
module lcic_tracker
  import lcic_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic                          adv,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic                          last_point,
  output logic                          pre_vld,
  output lane_t                         pre_lane_l,
  output lane_t                         pre_lane_r
);

  localparam int SCALE = SCALE_REF - COORD_WIDTH;

  logic signed [COORD_WIDTH-1:0] lx_r, ly_r, gx_r, gy_r;
  logic signed [COORD_WIDTH-1:0] lx_nxt, ly_nxt, gx_nxt, gy_nxt;
  logic                          await_r;
  logic                          pre_vld_r;
  lane_t                         lane_l_r, lane_r_r;

  function automatic lane_t prep(input logic signed [COORD_WIDTH-1:0] px,
                                 input logic signed [COORD_WIDTH-1:0] py);
    lane_t                    a;
    logic signed [LANE_W-1:0] xe, ye;
    xe = LANE_W'(px);
    ye = LANE_W'(py);
    a.z         = '0;
    a.fixed     = 1'b0;
    a.fixed_ang = '0;
    a.base      = '0;
    if (px == '0) begin
      a.fixed     = 1'b1;
      a.fixed_ang = py[COORD_WIDTH-1] ? -ANG_HALF_PI : ANG_HALF_PI;
    end else if (py == '0) begin
      a.fixed     = 1'b1;
      a.fixed_ang = px[COORD_WIDTH-1] ? ANG_PI : '0;
    end
    if (px[COORD_WIDTH-1]) begin
      a.base = py[COORD_WIDTH-1] ? -ANG_PI : ANG_PI;
      xe = -xe;
      ye = -ye;
    end
    a.x = xe <<< SCALE;
    a.y = ye <<< SCALE;
    return a;
  endfunction

  always_comb begin
    if (await_r) begin
      lx_nxt = point_x;
      ly_nxt = point_y;
      gx_nxt = point_x;
      gy_nxt = point_y;
    end else begin
      lx_nxt = lx_r;
      ly_nxt = ly_r;
      gx_nxt = gx_r;
      gy_nxt = gy_r;
      // strict compares: on a tie the earlier point stays
      if (point_y < ly_r) begin
        lx_nxt = point_x;
        ly_nxt = point_y;
      end
      if (point_y > gy_r) begin
        gx_nxt = point_x;
        gy_nxt = point_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lx_r      <= '0;
      ly_r      <= '0;
      gx_r      <= '0;
      gy_r      <= '0;
      await_r   <= 1'b1;
      pre_vld_r <= 1'b0;
    end else begin
      if (accept) begin
        lx_r    <= lx_nxt;
        ly_r    <= ly_nxt;
        gx_r    <= gx_nxt;
        gy_r    <= gy_nxt;
        await_r <= last_point;
      end
      if (adv) begin
        pre_vld_r <= accept && last_point;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lane_l_r <= prep(lx_nxt, ly_nxt);
      lane_r_r <= prep(gx_nxt, gy_nxt);
    end
  end

  assign pre_vld    = pre_vld_r;
  assign pre_lane_l = lane_l_r;
  assign pre_lane_r = lane_r_r;

endmodule

// ----- rtl/lcic_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// lcic_cordic_cell
// One vectoring micro-rotation for both kept points, registered.
// ----------------------------------------------------------------------------
module lcic_cordic_cell
  import lcic_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  adv,
  input  logic  in_vld,
  input  lane_t in_lane_l,
  input  lane_t in_lane_r,
  output logic  out_vld,
  output lane_t out_lane_l,
  output lane_t out_lane_r
);

  localparam logic [Z_W-1:0] ATAN_STEP = atan_entry(5'(STEP));

  logic  vld_r;
  lane_t lane_l_r, lane_r_r;

  function automatic lane_t rotate(input lane_t a);
    lane_t                    r;
    logic signed [LANE_W-1:0] dx, dy;
    dx = a.y >>> STEP;
    dy = a.x >>> STEP;
    r  = a;
    if (!a.y[LANE_W-1]) begin
      r.x = a.x + dx;
      r.y = a.y - dy;
      r.z = a.z + $signed(ATAN_STEP);
    end else begin
      r.x = a.x - dx;
      r.y = a.y + dy;
      r.z = a.z - $signed(ATAN_STEP);
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lane_l_r <= rotate(in_lane_l);
      lane_r_r <= rotate(in_lane_r);
    end
  end

  assign out_vld    = vld_r;
  assign out_lane_l = lane_l_r;
  assign out_lane_r = lane_r_r;

endmodule

// ----- rtl/lcic_window.sv -----
// ----------------------------------------------------------------------------
// lcic_window
// Rounds the rotator angles, classifies them against the field of view and
// forms the pixel window.
// ----------------------------------------------------------------------------
module lcic_window
  import lcic_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    adv,
  input  cfg_t    cfg,
  input  logic    in_vld,
  input  lane_t   in_lane_l,
  input  lane_t   in_lane_r,
  output logic    res_vld,
  output result_t res
);

  logic                    vld_a_r, vld_b_r;
  logic signed [ANG_W-1:0] al_a_r, ar_a_r;
  logic signed [ANG_W-1:0] al_b_r, ar_b_r;
  logic [2:0]              st_b_r, st_nxt;
  logic signed [29:0]      prod_l_r, prod_r_r;
  logic [11:0]             ctr_b_r;

  logic signed [16:0] h_s, al_s, ar_s;
  logic               lt_l, gt_l, in_l, lt_r, gt_r, in_r;
  logic signed [16:0] pix_l, pix_r, xl, xr;
  logic signed [18:0] off_s, wid_s;

  function automatic logic signed [ANG_W-1:0] finish(input lane_t a);
    logic signed [Z_W:0] zr, s;
    logic signed [Z_W:0] pi_w;
    logic signed [ANG_W-1:0] r;
    pi_w = (Z_W+1)'(ANG_PI);
    zr   = (Z_W+1)'(a.z) + $signed((Z_W+1)'(1024));
    zr   = zr >>> 11;
    s    = zr + (Z_W+1)'(a.base);
    if (s > pi_w) begin
      r = ANG_PI;
    end else if (s < -pi_w) begin
      r = -ANG_PI;
    end else begin
      r = s[ANG_W-1:0];
    end
    if (a.fixed) begin
      r = a.fixed_ang;
    end
    return r;
  endfunction

  function automatic logic signed [16:0] trunc_pix(input logic signed [29:0] p);
    logic signed [29:0] adj;
    // round toward zero: bias negative products before the shift
    adj = p + (p[29] ? 30'sd8191 : 30'sd0);
    return 17'(adj >>> 13);
  endfunction

  function automatic logic [12:0] sat_win(input logic signed [18:0] v);
    logic [12:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({6'd0, WIN_MAX})) begin
      r = WIN_MAX;
    end else begin
      r = v[12:0];
    end
    return r;
  endfunction

  // stage A: angles
  always_ff @(posedge clk) begin
    if (adv) begin
      al_a_r <= finish(in_lane_l);
      ar_a_r <= finish(in_lane_r);
    end
  end

  // stage B: classify and scale to pixels
  always_comb begin
    h_s  = $signed({3'd0, cfg.half_fov});
    al_s = 17'(al_a_r);
    ar_s = 17'(ar_a_r);
    lt_l = al_s < -h_s;
    gt_l = al_s > h_s;
    in_l = (al_s > -h_s) && (al_s < h_s);
    lt_r = ar_s < -h_s;
    gt_r = ar_s > h_s;
    in_r = (ar_s > -h_s) && (ar_s < h_s);
    if (!(al_a_r < ar_a_r)) begin
      st_nxt = ST_ORDER_ERR;
    end else if ((lt_l && lt_r) || (gt_l && gt_r)) begin
      st_nxt = ST_OUTSIDE;
    end else if (lt_l && gt_r) begin
      st_nxt = ST_BOTH_CLIP;
    end else if (lt_l && in_r) begin
      st_nxt = ST_LEFT_CLIP;
    end else if (gt_r && in_l) begin
      st_nxt = ST_RIGHT_CLIP;
    end else if (in_l && in_r) begin
      st_nxt = ST_IN_RANGE;
    end else begin
      st_nxt = ST_BOUNDARY;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      al_b_r   <= al_a_r;
      ar_b_r   <= ar_a_r;
      st_b_r   <= st_nxt;
      prod_l_r <= 30'(al_a_r) * 30'($signed({1'b0, cfg.pix_rate}));
      prod_r_r <= 30'(ar_a_r) * 30'($signed({1'b0, cfg.pix_rate}));
      ctr_b_r  <= cfg.img_width[12:1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else if (adv) begin
      vld_a_r <= in_vld;
      vld_b_r <= vld_a_r;
    end
  end

  // window edges relative to image center
  always_comb begin
    pix_l = trunc_pix(prod_l_r);
    pix_r = trunc_pix(prod_r_r);
    if ((st_b_r == ST_BOTH_CLIP) || (st_b_r == ST_LEFT_CLIP)) begin
      xl = -$signed({5'd0, ctr_b_r});
    end else begin
      xl = pix_l;
    end
    if ((st_b_r == ST_BOTH_CLIP) || (st_b_r == ST_RIGHT_CLIP)) begin
      xr = $signed({5'd0, ctr_b_r});
    end else begin
      xr = pix_r;
    end
    off_s = $signed({7'd0, ctr_b_r}) + 19'(xl);
    wid_s = 19'(xr) - 19'(xl);
    res.status      = st_b_r;
    res.left_angle  = al_b_r;
    res.right_angle = ar_b_r;
    if (st_b_r <= ST_BOTH_CLIP) begin
      res.offset = sat_win(off_s);
      res.width  = sat_win(wid_s);
    end else begin
      res.offset = '0;
      res.width  = '0;
    end
  end

  assign res_vld = vld_b_r;

endmodule

// ----- rtl/lidar_cluster_to_image_columns_unit.sv -----
// ----------------------------------------------------------------------------
// lidar_cluster_to_image_columns_unit
// Cluster-to-image-column window: extreme-y points, CORDIC bearing angles,
// field-of-view classification and pixel window.
// ----------------------------------------------------------------------------
// Points are taken one per cycle unless a last point is stalled. A point without
// last_point only updates the kept least-y and greatest-y points and never stalls.
// The last point of a cluster sends both kept points down a row of CORDIC_STEPS
// rotation cells (capped at 24); its result passes one load stage, one cell per
// iteration, an angle rounding stage, a classify and multiply stage, and the
// output register. Clusters follow each other back to back, so a last point may
// arrive every cycle while the row is not held. The whole row advances together;
// it holds only while the output register carries a result that is stalled, and
// only a last point is stalled at the input then. Configuration registers (half_fov
// at 0x0, pixels_per_radian at 0x4, image_width at 0x8) are written over the APB
// port; the user must write them only while no cluster is in flight (not enforced).
// ----------------------------------------------------------------------------
`include "lidar_cluster_to_image_columns_unit_defines.svh"

module lidar_cluster_to_image_columns_unit
  import lcic_pkg::*;
#(
  parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // point channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_point_x,
  input  logic signed [COORD_WIDTH-1:0] in_point_y,
  input  logic                          in_last_point,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    out_status,
  output logic signed [ANG_W-1:0]       out_left_angle,
  output logic signed [ANG_W-1:0]       out_right_angle,
  output logic [12:0]                   out_window_offset,
  output logic [12:0]                   out_window_width,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int STEPS = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;

  cfg_t    cfg_r;
  logic    adv;
  logic    accept;
  logic    out_valid_r;
  result_t res_r;
  result_t res_w;
  logic    res_vld;

  logic  vld_c [0:STEPS];
  lane_t lane_l_c [0:STEPS];
  lane_t lane_r_c [0:STEPS];

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_fov  <= HALF_FOV_RST;
      cfg_r.pix_rate  <= PIX_RATE_RST;
      cfg_r.img_width <= IMG_WIDTH_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_HALF_FOV:  cfg_r.half_fov  <= pwdata[13:0];
        REG_PIX_RATE:  cfg_r.pix_rate  <= pwdata[12:0];
        REG_IMG_WIDTH: cfg_r.img_width <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_HALF_FOV:  prdata = {18'd0, cfg_r.half_fov};
      REG_PIX_RATE:  prdata = {19'd0, cfg_r.pix_rate};
      REG_IMG_WIDTH: prdata = {19'd0, cfg_r.img_width};
      default:       prdata = '0;
    endcase
  end

  // -------------------------------------------------------------- pipeline
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = in_last_point && !adv;
  assign accept   = in_valid && !in_stall;

  lcic_tracker #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_tracker (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .adv        (adv),
    .point_x    (in_point_x),
    .point_y    (in_point_y),
    .last_point (in_last_point),
    .pre_vld    (vld_c[0]),
    .pre_lane_l (lane_l_c[0]),
    .pre_lane_r (lane_r_c[0])
  );

  for (genvar k = 0; k < STEPS; k++) begin : g_cell
    lcic_cordic_cell #(
      .STEP (k)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .adv        (adv),
      .in_vld     (vld_c[k]),
      .in_lane_l  (lane_l_c[k]),
      .in_lane_r  (lane_r_c[k]),
      .out_vld    (vld_c[k+1]),
      .out_lane_l (lane_l_c[k+1]),
      .out_lane_r (lane_r_c[k+1])
    );
  end

  lcic_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .cfg       (cfg_r),
    .in_vld    (vld_c[STEPS]),
    .in_lane_l (lane_l_c[STEPS]),
    .in_lane_r (lane_r_c[STEPS]),
    .res_vld   (res_vld),
    .res       (res_w)
  );

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_w;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = res_r.status;
  assign out_left_angle    = res_r.left_angle;
  assign out_right_angle   = res_r.right_angle;
  assign out_window_offset = res_r.offset;
  assign out_window_width  = res_r.width;

  // ------------------------------------------------------------ assertions
  `LCIC_ASSERT_NEXT(a_last_loads_row, accept && in_last_point, vld_c[0], "last point not loaded")
  `LCIC_ASSERT_NOW(a_no_window, out_valid && (out_status == ST_OUTSIDE || out_status == ST_ORDER_ERR || out_status == ST_BOUNDARY), out_window_offset == '0 && out_window_width == '0, "window set without range")
  `LCIC_ASSERT_NOW(a_angle_order, out_valid && out_status != ST_ORDER_ERR, out_left_angle < out_right_angle, "angle order wrong")

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// Cluster window block testbench
// Streams clusters of laser points into the block and checks every window
// result against a bit-exact predictor. The predictor keeps the extreme-y
// points and runs its own CORDIC bearing, field-of-view test and pixel
// window math. Points, stalls and idle cycles are random. The run covers
// directed corner clusters, extreme and out-of-range register settings, a
// long receiver hold that backs up the pipeline, and a no-idle stretch.
// ----------------------------------------------------------------------------
module testbench;
  import lcic_pkg::*;

  localparam int RESULT_LATENCY = 20;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_BOUND    = 3000;
  localparam int CYCLE_LIMIT    = 60000;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               last;
  } point_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic signed [15:0] in_point_x = '0;
  logic signed [15:0] in_point_y = '0;
  logic        in_last_point = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic signed [15:0] out_left_angle;
  logic signed [15:0] out_right_angle;
  logic [12:0] out_window_offset;
  logic [12:0] out_window_width;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  lidar_cluster_to_image_columns_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_point_x        (in_point_x),
    .in_point_y        (in_point_y),
    .in_last_point     (in_last_point),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_left_angle    (out_left_angle),
    .out_right_angle   (out_right_angle),
    .out_window_offset (out_window_offset),
    .out_window_width  (out_window_width),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register shadow
  logic [13:0] fov_q13      = HALF_FOV_RST;
  logic [12:0] cols_per_rad = PIX_RATE_RST;
  logic [12:0] img_cols     = IMG_WIDTH_RST;

  // kept extreme-y points of the open cluster
  longint lo_x = 0, lo_y = 0, hi_x = 0, hi_y = 0;
  bit     fresh_cluster = 1'b1;

  longint atan_q24 [0:15] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
                              262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048,
                              1024, 512};

  point_t  pending_points[$];
  result_t windows_due[$];
  point_t  next_point;
  result_t seen_window, due_window;

  bit point_accepted = 1'b0;
  int send_idle_pct = 28;
  int stall_pct = 28;
  int holds_asked = 0;
  int holds_served = 0;
  int hold_left = 0;

  int error_count = 0;
  int points_queued = 0;
  int points_taken = 0;
  int clusters_closed = 0;
  int windows_checked = 0;
  int reg_settings = 0;
  int status_seen [0:7];

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  // bearing atan2(y,x) in [-pi,pi], radians Q13
  function automatic longint bearing_q13(input longint px, input longint py);
    longint x, y, z, base, dx, dy, r;
    int i;
    x = px;
    y = py;
    z = 0;
    base = 0;
    if (x == 0) return (y < 0) ? -longint'(ANG_HALF_PI) : longint'(ANG_HALF_PI);
    if (y == 0) return (x > 0) ? 0 : longint'(ANG_PI);
    if (x < 0) begin
      base = (y >= 0) ? longint'(ANG_PI) : -longint'(ANG_PI);
      x = -x;
      y = -y;
    end
    x = x <<< 24;
    y = y <<< 24;
    for (i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + atan_q24[i];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - atan_q24[i];
      end
    end
    r = ((z + 1024) >>> 11) + base;
    if (r > longint'(ANG_PI)) r = longint'(ANG_PI);
    if (r < -longint'(ANG_PI)) r = -longint'(ANG_PI);
    return r;
  endfunction

  function automatic logic [12:0] clamp_window(input longint v);
    if (v < 0) return '0;
    if (v > longint'(WIN_MAX)) return WIN_MAX;
    return v[12:0];
  endfunction

  function automatic result_t predict_window();
    longint al, ar, h, rate, c, xl, xr;
    result_t w;
    al = bearing_q13(lo_x, lo_y);
    ar = bearing_q13(hi_x, hi_y);
    h = longint'(fov_q13);
    rate = longint'(cols_per_rad);
    c = longint'(img_cols / 2);
    xl = 0;
    xr = 0;
    if (!(al < ar)) begin
      w.status = ST_ORDER_ERR;
    end else if ((al < -h && ar < -h) || (al > h && ar > h)) begin
      w.status = ST_OUTSIDE;
    end else if (al < -h && ar > h) begin
      w.status = ST_BOTH_CLIP;
      xl = -c;
      xr = c;
    end else if (al < -h && ar > -h && ar < h) begin
      w.status = ST_LEFT_CLIP;
      xl = -c;
      xr = (ar * rate) / 8192;
    end else if (ar > h && al > -h && al < h) begin
      w.status = ST_RIGHT_CLIP;
      xr = c;
      xl = (al * rate) / 8192;
    end else if (al > -h && al < h && ar > -h && ar < h) begin
      w.status = ST_IN_RANGE;
      xl = (al * rate) / 8192;
      xr = (ar * rate) / 8192;
    end else begin
      w.status = ST_BOUNDARY;
    end
    w.left_angle = al[15:0];
    w.right_angle = ar[15:0];
    if (w.status <= ST_BOTH_CLIP) begin
      w.offset = clamp_window(c + xl);
      w.width = clamp_window(xr - xl);
    end else begin
      w.offset = '0;
      w.width = '0;
    end
    return w;
  endfunction

  task automatic absorb_point(input longint x, input longint y, input logic last);
    if (fresh_cluster) begin
      lo_x = x;
      lo_y = y;
      hi_x = x;
      hi_y = y;
      fresh_cluster = 1'b0;
    end else begin
      // strict compares: on a tie the earlier point stays
      if (y < lo_y) begin
        lo_x = x;
        lo_y = y;
      end
      if (y > hi_y) begin
        hi_x = x;
        hi_y = y;
      end
    end
    points_taken++;
    if (last) begin
      windows_due = {windows_due, predict_window()};
      fresh_cluster = 1'b1;
      clusters_closed++;
    end
  endtask

  // point driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !point_accepted) begin
      // hold the offered point until the transfer happens
    end else if (pending_points.size() == 0 || $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
    end else begin
      next_point = pending_points.pop_front();
      in_valid <= 1'b1;
      in_point_x <= next_point.x;
      in_point_y <= next_point.y;
      in_last_point <= next_point.last;
    end
  end

  // result receiver stall
  always @(negedge clk) begin
    if (hold_left == 0 && holds_served < holds_asked) begin
      hold_left = HOLD_CYCLES;
      holds_served++;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // monitor: predict on each point transfer, check each result transfer
  always @(posedge clk) begin
    point_accepted = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        point_accepted = 1'b1;
        absorb_point(longint'(in_point_x), longint'(in_point_y), in_last_point);
      end
      if (out_valid && !out_stall) begin
        seen_window.status = out_status;
        seen_window.left_angle = out_left_angle;
        seen_window.right_angle = out_right_angle;
        seen_window.offset = out_window_offset;
        seen_window.width = out_window_width;
        if (windows_due.size() == 0) begin
          flag_error($sformatf("window result with no cluster pending, status %0d",
                               seen_window.status));
        end else begin
          due_window = windows_due.pop_front();
          windows_checked++;
          status_seen[due_window.status]++;
          if (seen_window.status !== due_window.status)
            flag_error($sformatf("status got %0d want %0d",
                                 seen_window.status, due_window.status));
          if (seen_window.left_angle !== due_window.left_angle)
            flag_error($sformatf("left_angle got %0d want %0d",
                                 seen_window.left_angle, due_window.left_angle));
          if (seen_window.right_angle !== due_window.right_angle)
            flag_error($sformatf("right_angle got %0d want %0d",
                                 seen_window.right_angle, due_window.right_angle));
          if (seen_window.offset !== due_window.offset)
            flag_error($sformatf("window_offset got %0d want %0d",
                                 seen_window.offset, due_window.offset));
          if (seen_window.width !== due_window.width)
            flag_error($sformatf("window_width got %0d want %0d",
                                 seen_window.width, due_window.width));
        end
      end
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] word);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= word;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_HALF_FOV:  fov_q13 = word[13:0];
      REG_PIX_RATE:  cols_per_rad = word[12:0];
      REG_IMG_WIDTH: img_cols = word[12:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic reg_read(input logic [1:0] idx, output logic [31:0] word);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    word = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_regs();
    logic [31:0] word;
    reg_read(REG_HALF_FOV, word);
    if (word !== {18'd0, fov_q13})
      flag_error($sformatf("half_fov reads %0h want %0h", word, fov_q13));
    reg_read(REG_PIX_RATE, word);
    if (word !== {19'd0, cols_per_rad})
      flag_error($sformatf("pixels_per_radian reads %0h want %0h", word, cols_per_rad));
    reg_read(REG_IMG_WIDTH, word);
    if (word !== {19'd0, img_cols})
      flag_error($sformatf("image_width reads %0h want %0h", word, img_cols));
  endtask

  task automatic set_regs(input logic [31:0] fov, input logic [31:0] rate,
                          input logic [31:0] width);
    reg_write(REG_HALF_FOV, fov);
    reg_write(REG_PIX_RATE, rate);
    reg_write(REG_IMG_WIDTH, width);
    check_regs();
    reg_settings++;
  endtask

  function automatic longint pick(input longint lo, input longint hi);
    return lo + longint'($urandom_range(32'(hi - lo)));
  endfunction

  function automatic logic signed [15:0] clip16(input longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  task automatic push_point(input logic signed [15:0] x, input logic signed [15:0] y,
                            input logic last);
    point_t p;
    p.x = x;
    p.y = y;
    p.last = last;
    pending_points = {pending_points, p};
    points_queued++;
  endtask

  // one random cluster: mostly tight groups ahead of the sensor, some scattered,
  // raw or axis-heavy
  task automatic queue_cluster();
    int kind, n, i;
    longint cx, cy, spread, xs;
    logic signed [15:0] x, y, prev_y;
    kind = $urandom_range(99);
    cx = 0;
    cy = 0;
    spread = 0;
    xs = 0;
    prev_y = '0;
    if (kind < 45 || kind >= 93) begin
      cx = pick(300, 32767);
      cy = pick(-cx, cx);
      spread = pick(1, 4000);
      xs = spread / 4;
      n = (kind < 45) ? int'(pick(2, 6)) : int'(pick(10, 30));
    end else if (kind < 60) begin
      cx = pick(-32768, 32767);
      cy = pick(-32768, 32767);
      spread = pick(1, 20000);
      xs = spread;
      n = int'(pick(2, 8));
    end else if (kind < 85) begin
      n = (kind < 78) ? int'(pick(1, 6)) : 1;
    end else begin
      n = int'(pick(1, 4));
    end
    for (i = 0; i < n; i++) begin
      if (kind < 60 || kind >= 93) begin
        x = clip16(cx + pick(-xs, xs));
        y = clip16(cy + pick(-spread, spread));
      end else if (kind < 85) begin
        x = 16'($urandom());
        y = 16'($urandom());
      end else begin
        x = 16'($urandom());
        y = 16'($urandom());
        case ($urandom_range(7))
          0: x = '0;
          1: y = '0;
          2: begin x = '0; y = '0; end
          3: x = -16'sd32768;
          4: y = -16'sd32768;
          5: x = 16'sd32767;
          6: y = 16'sd32767;
          default: ;
        endcase
      end
      if (i > 0 && $urandom_range(9) == 0) y = prev_y;
      prev_y = y;
      push_point(x, y, i == n - 1);
    end
  endtask

  task automatic queue_random(input int count);
    int start;
    start = points_queued;
    while (points_queued - start < count) queue_cluster();
  endtask

  // wait until every point is taken and every window has come back
  task automatic wait_idle();
    int waited;
    waited = 0;
    while (pending_points.size() != 0 || in_valid) @(posedge clk);
    while (windows_due.size() != 0 && waited < DRAIN_BOUND) begin
      @(posedge clk);
      waited++;
    end
    while (windows_due.size() != 0) begin
      due_window = windows_due.pop_front();
      flag_error($sformatf("window never arrived, status %0d", due_window.status));
    end
    repeat (RESULT_LATENCY + 4) @(posedge clk);
  endtask

  initial begin
    #(CYCLE_LIMIT * 10);
    $display("status: fail");
    $finish;
  end

  initial begin
    int k;
    for (k = 0; k < 8; k++) status_seen[k] = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);
    check_regs();

    // directed corner clusters at reset settings
    push_point(16'sd100, 16'sd50, 1'b1);
    push_point(16'sd0, 16'sd1000, 1'b0);
    push_point(16'sd0, -16'sd1000, 1'b1);
    push_point(16'sd5000, -16'sd200, 1'b0);
    push_point(16'sd5000, 16'sd300, 1'b1);
    push_point(16'sd1000, -16'sd3000, 1'b0);
    push_point(16'sd5000, 16'sd100, 1'b1);
    push_point(16'sd5000, -16'sd100, 1'b0);
    push_point(16'sd1000, 16'sd3000, 1'b1);
    push_point(16'sd1000, 16'sd2000, 1'b0);
    push_point(16'sd1000, 16'sd3000, 1'b1);
    push_point(16'sd1000, 16'sd100, 1'b0);
    push_point(16'sd2000, 16'sd100, 1'b0);
    push_point(16'sd3000, -16'sd50, 1'b0);
    push_point(16'sd4000, -16'sd50, 1'b1);
    push_point(16'sd700, 16'sd0, 1'b0);
    push_point(-16'sd30000, 16'sd5, 1'b1);
    push_point(16'sd0, 16'sd0, 1'b0);
    push_point(16'sd300, -16'sd400, 1'b1);
    push_point(16'sd0, 16'sd0, 1'b1);
    push_point(-16'sd32768, -16'sd32768, 1'b0);
    push_point(16'sd32767, 16'sd32767, 1'b0);
    push_point(-16'sd32768, 16'sd32767, 1'b1);
    push_point(16'sd32767, -16'sd32768, 1'b1);
    wait_idle();

    // widest field: an axis point lands exactly on the edge
    set_regs(32'd12868, 32'd8191, 32'd4096);
    push_point(16'sd1000, -16'sd500, 1'b0);
    push_point(16'sd0, 16'sd1000, 1'b1);
    queue_random(150);
    wait_idle();

    set_regs(32'd1, 32'd1, 32'd2);
    queue_random(150);
    wait_idle();

    // all-ones words: mask to register width
    set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_random(100);
    wait_idle();

    set_regs(32'd0, 32'd0, 32'd0);
    queue_random(50);
    wait_idle();

    // no idling on either side
    send_idle_pct = 0;
    stall_pct = 0;
    set_regs(32'd4289, 32'd611, 32'd640);
    queue_random(200);
    wait_idle();

    // long receiver hold while last points keep coming: fill the row
    for (k = 0; k < 150; k++)
      push_point(16'($urandom()), 16'($urandom()), (k == 149) || ($urandom_range(3) != 0));
    holds_asked++;
    wait_idle();
    send_idle_pct = 28;
    stall_pct = 28;

    // sender pauses mid-setting until every window is back
    queue_random(100);
    wait_idle();
    queue_random(100);
    wait_idle();

    for (k = 0; k < 3; k++) begin
      set_regs(32'($urandom_range(12868, 1)), 32'($urandom_range(8191, 1)),
               32'($urandom_range(4096, 2)));
      queue_random(150);
      wait_idle();
    end

    repeat (RESULT_LATENCY + 10) @(posedge clk);
    $display("covered %0d points in %0d clusters, %0d windows checked, %0d register settings",
             points_taken, clusters_closed, windows_checked, reg_settings + 1);
    $display("window status mix: in %0d, left %0d, right %0d, both %0d,",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             " out %0d, order %0d, edge %0d",
             status_seen[4], status_seen[5], status_seen[6]);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
